// File: rtl/core/assert_macros.svh
// assertion macros shared by the hash block modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define TCFH_ASSERT(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("check failed: %m");

// antecedent implies consequent in the same cycle
`define TCFH_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed: %m");

// antecedent implies consequent in the next cycle
`define TCFH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed: %m");

`endif

// File: rtl/core/tcfh_pkg.sv
// types, constants and functions of the trimmed case-folded fnv-1a 64 hash
package tcfh_pkg;

   localparam int MAX_FIELD_BYTES = 1024;
   localparam int PEND_W = $clog2(MAX_FIELD_BYTES + 1);

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [7:0] SEP_CHAR = 8'h7C;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] NUL_CHAR = 8'h00;
   localparam logic [7:0] CASE_DIFF = 8'h20;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;

   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_FIELD_END = 2'd1;
   localparam logic [1:0] MODE_RECORD_END = 2'd2;

   typedef enum logic [1:0] {
      PHASE_LEAD,
      PHASE_TEXT,
      PHASE_DONE
   } phase_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MIX_IN,
      OP_HOLD,
      OP_MIX_SPACE,
      OP_MIX_HELD,
      OP_SPACE,
      OP_NUL,
      OP_END_FIELD,
      OP_END_RECORD
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_END_WAIT
   } ctrl_state_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic phase_done;
      logic byte_nul;
      logic byte_space;
      logic pend_zero;
      logic out_free;
   } dp_stat_type;

   // fnv-1a step: xor then multiply by prime 2^40 + 0x1b3, as shift-add
   function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] b);
      return (b >= LOWER_A && b <= LOWER_Z) ? b - CASE_DIFF : b;
   endfunction

endpackage

// File: rtl/core/tcfh_if.sv
// valid/ready channel interfaces for request bytes and hash results
interface tcfh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface tcfh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   logic        identity_found;

   modport source (output valid, output hash_value, output identity_found, input ready);
   modport sink (input valid, input hash_value, input identity_found, output ready);
endinterface

// File: rtl/core/tcfh_dp.sv
// datapath: running hash, field trim state, held byte and result register
`include "assert_macros.svh"

module tcfh_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           data_byte,
   input  tcfh_pkg::dp_cmd_type cmd,
   output tcfh_pkg::dp_stat_type stat,
   tcfh_rsp_if.source           rsp
);

   logic [63:0]                hash_ff, hash_in;
   logic                       seen_ff, seen_in;
   tcfh_pkg::phase_type        phase_ff, phase_in;
   logic [tcfh_pkg::PEND_W-1:0] pend_ff, pend_in;
   logic [7:0]                 held_ff, held_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [63:0]                rsp_hash_ff, rsp_hash_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [7:0]                 mix_byte;
   logic [63:0]                mix_out;
   logic                       load_rsp;

   // one shared mixer, byte picked by the command
   always_comb begin
      case (cmd.op)
         tcfh_pkg::OP_MIX_IN:    mix_byte = tcfh_pkg::fold_upper(data_byte);
         tcfh_pkg::OP_MIX_SPACE: mix_byte = tcfh_pkg::SPACE_CHAR;
         tcfh_pkg::OP_MIX_HELD:  mix_byte = held_ff;
         default:                mix_byte = tcfh_pkg::SEP_CHAR;
      endcase
   end

   assign mix_out = tcfh_pkg::fnv_mix(hash_ff, mix_byte);

   always_comb begin
      hash_in      = hash_ff;
      seen_in      = seen_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      held_in      = held_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_found_in = rsp_found_ff;
      load_rsp     = 1'b0;
      unique case (cmd.op)
         tcfh_pkg::OP_NONE: begin
         end
         tcfh_pkg::OP_MIX_IN, tcfh_pkg::OP_MIX_HELD: begin
            hash_in  = mix_out;
            seen_in  = 1'b1;
            phase_in = tcfh_pkg::PHASE_TEXT;
         end
         tcfh_pkg::OP_HOLD: begin
            held_in = tcfh_pkg::fold_upper(data_byte);
         end
         tcfh_pkg::OP_MIX_SPACE: begin
            hash_in = mix_out;
            pend_in = pend_ff - 1'b1;
         end
         tcfh_pkg::OP_SPACE: begin
            if (phase_ff == tcfh_pkg::PHASE_TEXT &&
                pend_ff < tcfh_pkg::PEND_W'(tcfh_pkg::MAX_FIELD_BYTES)) begin
               pend_in = pend_ff + 1'b1;
            end
         end
         tcfh_pkg::OP_NUL: begin
            phase_in = tcfh_pkg::PHASE_DONE;
            pend_in  = '0;
         end
         tcfh_pkg::OP_END_FIELD: begin
            hash_in  = mix_out;
            phase_in = tcfh_pkg::PHASE_LEAD;
            pend_in  = '0;
         end
         tcfh_pkg::OP_END_RECORD: begin
            load_rsp     = 1'b1;
            rsp_hash_in  = seen_ff ? mix_out : 64'd0;
            rsp_found_in = seen_ff;
            hash_in      = tcfh_pkg::FNV_BASIS;
            seen_in      = 1'b0;
            phase_in     = tcfh_pkg::PHASE_LEAD;
            pend_in      = '0;
         end
         default: begin
         end
      endcase
      rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= tcfh_pkg::FNV_BASIS;
         seen_ff      <= 1'b0;
         phase_ff     <= tcfh_pkg::PHASE_LEAD;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         seen_ff      <= seen_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff      <= held_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign stat.phase_done = (phase_ff == tcfh_pkg::PHASE_DONE);
   assign stat.byte_nul   = (data_byte == tcfh_pkg::NUL_CHAR);
   assign stat.byte_space = (data_byte == tcfh_pkg::SPACE_CHAR);
   assign stat.pend_zero  = (pend_ff == '0);
   assign stat.out_free   = ~rsp_valid_ff | rsp.ready;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.hash_value     = rsp_hash_ff;
   assign rsp.identity_found = rsp_found_ff;

   `TCFH_ASSERT(pend_in_range, pend_ff <= tcfh_pkg::PEND_W'(tcfh_pkg::MAX_FIELD_BYTES))
   `TCFH_ASSERT_IMP(pend_only_in_text, pend_ff != '0, phase_ff == tcfh_pkg::PHASE_TEXT)
   `TCFH_ASSERT_NEXT(space_flush_counts, cmd.op == tcfh_pkg::OP_MIX_SPACE, pend_ff == $past(pend_ff) - 1'b1)
   `TCFH_ASSERT_IMP(rsp_zero_without_text, rsp_valid_ff && !rsp_found_ff, rsp_hash_ff == 64'd0)

endmodule

// File: rtl/core/tcfh_ctrl.sv
// controller: request handshake and command sequencing for the datapath
`include "assert_macros.svh"

module tcfh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   tcfh_req_if.sink              req,
   input  tcfh_pkg::dp_stat_type stat,
   output tcfh_pkg::dp_cmd_type  cmd
);

   tcfh_pkg::ctrl_state_type state_ff, state_in;
   logic                     take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcfh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = tcfh_pkg::OP_NONE;
      req.ready = 1'b0;
      take      = 1'b0;
      unique case (state_ff)
         tcfh_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            take      = req.valid;
            if (take) begin
               case (req.mode)
                  tcfh_pkg::MODE_BYTE: begin
                     if (stat.phase_done) begin
                        cmd.op = tcfh_pkg::OP_NONE;
                     end else if (stat.byte_nul) begin
                        cmd.op = tcfh_pkg::OP_NUL;
                     end else if (stat.byte_space) begin
                        cmd.op = tcfh_pkg::OP_SPACE;
                     end else if (stat.pend_zero) begin
                        cmd.op = tcfh_pkg::OP_MIX_IN;
                     end else begin
                        cmd.op   = tcfh_pkg::OP_HOLD;
                        state_in = tcfh_pkg::ST_FLUSH;
                     end
                  end
                  tcfh_pkg::MODE_FIELD_END: begin
                     cmd.op = tcfh_pkg::OP_END_FIELD;
                  end
                  tcfh_pkg::MODE_RECORD_END: begin
                     if (stat.out_free) begin
                        cmd.op = tcfh_pkg::OP_END_RECORD;
                     end else begin
                        state_in = tcfh_pkg::ST_END_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tcfh_pkg::ST_FLUSH: begin
            if (!stat.pend_zero) begin
               cmd.op = tcfh_pkg::OP_MIX_SPACE;
            end else begin
               cmd.op   = tcfh_pkg::OP_MIX_HELD;
               state_in = tcfh_pkg::ST_IDLE;
            end
         end
         tcfh_pkg::ST_END_WAIT: begin
            if (stat.out_free) begin
               cmd.op   = tcfh_pkg::OP_END_RECORD;
               state_in = tcfh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcfh_pkg::ST_IDLE;
         end
      endcase
   end

   `TCFH_ASSERT_NEXT(hold_enters_flush, cmd.op == tcfh_pkg::OP_HOLD, state_ff == tcfh_pkg::ST_FLUSH)
   `TCFH_ASSERT_NEXT(flush_keeps_going, state_ff == tcfh_pkg::ST_FLUSH && !stat.pend_zero, state_ff == tcfh_pkg::ST_FLUSH)
   `TCFH_ASSERT_IMP(end_wait_needs_free, cmd.op == tcfh_pkg::OP_END_RECORD, stat.out_free)

endmodule

// File: rtl/core/trimmed_casefold_fnv1a64_hash.sv
// top level: trimmed, case-folded fnv-1a 64 hash over records of text fields
// latency: a record end transfer shows its result on rsp the next cycle, or the
//   cycle after a result still waiting in the output register transfers
// throughput: one byte or field end per cycle while not busy; a text byte that follows
//   held spaces holds off req while the shared mixer takes each space, then the byte
// reset: synchronous, active high; hash back to the offset basis, no result pending
`include "assert_macros.svh"

module trimmed_casefold_fnv1a64_hash (
   input  logic        clock,
   input  logic        reset,
   tcfh_req_if.sink    req_bus,
   tcfh_rsp_if.source  rsp_bus
);

   // command and status between sequencer and datapath
   tcfh_pkg::dp_cmd_type  cmd;
   tcfh_pkg::dp_stat_type stat;

   // sequencer: takes request transfers, turns held space runs into
   // one mixer step per space, waits on a busy result register
   tcfh_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath: single fnv mixer (prime as shift-add), trim state,
   // pending space count and the result register on the rsp side
   tcfh_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_bus.data_byte),
      .cmd       (cmd),
      .stat      (stat),
      .rsp       (rsp_bus)
   );

   // a result transfer only leaves after a record end was seen
   `TCFH_ASSERT_IMP(no_rsp_from_reset, $past(reset), !rsp_bus.valid)
   `TCFH_ASSERT_NEXT(rsp_after_record_end, cmd.op == tcfh_pkg::OP_END_RECORD, rsp_bus.valid)
   `TCFH_ASSERT_IMP(found_flag_matches_hash, rsp_bus.valid && rsp_bus.hash_value != 64'd0, rsp_bus.identity_found)

endmodule

// File: bench/trimmed_casefold_fnv1a64_hash_tb.sv
// testbench for the trimmed case-folded fnv-1a 64 hash: directed and random records, scoreboard
module trimmed_casefold_fnv1a64_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // the mode encoding left unused by the block, must be ignored
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // fnv 64 prime, 2^40 + 0x1b3
   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
   localparam int RANDOM_ITEMS = 240;
   localparam int MAX_GAP = 12;

   typedef struct {
      logic [63:0] hash_value;
      logic        identity_found;
   } record_digest_type;

   logic clock;
   logic reset;

   tcfh_req_if req_bus ();
   tcfh_rsp_if rsp_bus ();

   trimmed_casefold_fnv1a64_hash i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------------
   // hash predictor state, mirrors the block's architectural state
   // ---------------------------------------------------------------------------
   logic [63:0]         model_hash;
   logic                model_seen;
   tcfh_pkg::phase_type model_phase;
   int                  model_pending;

   // digests of record ends accepted but not yet seen on rsp, oldest first
   record_digest_type pending_digests[$];

   int  error_count = 0;
   int  items_sent = 0;
   bit  sender_no_gaps = 1'b0;
   bit  rsp_no_stall = 1'b0;
   // cycles the receiver should hold ready low, picked up by the drain process
   int  hold_request = 0;

   function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_PRIME;
   endfunction

   function automatic void clear_model();
      model_hash = tcfh_pkg::FNV_BASIS;
      model_seen = 1'b0;
      model_phase = tcfh_pkg::PHASE_LEAD;
      model_pending = 0;
   endfunction

   // advance the predictor by one accepted transfer, queue a digest on record end
   function automatic void predict_transfer(input logic [1:0] mode, input logic [7:0] data);
      logic [7:0]        folded;
      record_digest_type digest;
      case (mode)
         tcfh_pkg::MODE_BYTE: begin
            if (model_phase == tcfh_pkg::PHASE_DONE) begin
               // text already closed by a nul, rest of the field is ignored
            end else if (data == tcfh_pkg::NUL_CHAR) begin
               // nul closes the text and drops any held spaces
               model_phase = tcfh_pkg::PHASE_DONE;
               model_pending = 0;
            end else if (data == tcfh_pkg::SPACE_CHAR) begin
               // leading spaces vanish, inner ones are held with a saturating count
               if (model_phase == tcfh_pkg::PHASE_TEXT &&
                   model_pending < tcfh_pkg::MAX_FIELD_BYTES)
                  model_pending++;
            end else begin
               // held spaces were inner spaces after all, so mix them first
               repeat (model_pending)
                  model_hash = fnv_absorb(model_hash, tcfh_pkg::SPACE_CHAR);
               model_pending = 0;
               folded = (data >= tcfh_pkg::LOWER_A && data <= tcfh_pkg::LOWER_Z) ?
                        data - tcfh_pkg::CASE_DIFF : data;
               model_hash = fnv_absorb(model_hash, folded);
               model_seen = 1'b1;
               model_phase = tcfh_pkg::PHASE_TEXT;
            end
         end
         tcfh_pkg::MODE_FIELD_END, tcfh_pkg::MODE_RECORD_END: begin
            // trailing spaces are dropped, separator always mixed
            model_hash = fnv_absorb(model_hash, tcfh_pkg::SEP_CHAR);
            model_phase = tcfh_pkg::PHASE_LEAD;
            model_pending = 0;
            if (mode == tcfh_pkg::MODE_RECORD_END) begin
               digest.hash_value = model_seen ? model_hash : 64'd0;
               digest.identity_found = model_seen;
               pending_digests.push_back(digest);
               clear_model();
            end
         end
         default: begin
            // unused mode, no state change
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // request side: one transfer per call, random gap before it
   // ---------------------------------------------------------------------------
   task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         // payload is junk while valid is low
         req_bus.valid <= 1'b0;
         req_bus.mode <= 2'($urandom);
         req_bus.data_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.data_byte <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_transfer(mode, data);
      if (mode != MODE_UNUSED)
         items_sent++;
   endtask

   // mostly letters of both cases, some spaces, some arbitrary bytes
   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 11);
      if (r < 5)
         return 8'($urandom_range(tcfh_pkg::LOWER_A, tcfh_pkg::LOWER_Z));
      else if (r < 8)
         return 8'($urandom_range(8'h41, 8'h5A));
      else if (r < 10)
         return tcfh_pkg::SPACE_CHAR;
      else
         return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------------
   // response side: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : rsp_drain
      int gap;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_no_stall ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            if (hold_request > 0) begin
               // long back-pressure: block has to fill up and stall req
               rsp_bus.ready <= 1'b0;
               repeat (hold_request) @(posedge clock);
               hold_request = 0;
               rsp_bus.ready <= 1'b1;
            end
            @(posedge clock);
         end
      end
   end

   // scoreboard: compare each result transfer with the oldest queued digest
   always @(posedge clock) begin
      record_digest_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_digests.size() == 0) begin
            $error("result transfer with nothing expected: hash_value %h identity_found %b",
                   rsp_bus.hash_value, rsp_bus.identity_found);
            error_count++;
         end else begin
            want = pending_digests.pop_front();
            if (rsp_bus.hash_value !== want.hash_value) begin
               $error("hash_value: expected %h, actual %h", want.hash_value,
                      rsp_bus.hash_value);
               error_count++;
            end
            if (rsp_bus.identity_found !== want.identity_found) begin
               $error("identity_found: expected %b, actual %b", want.identity_found,
                      rsp_bus.identity_found);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // hand-picked records covering trimming, folding borders, nul and mode edges
   task automatic test_directed();
      // record end alone and empty fields: no identity, digest is zero
      send_item(tcfh_pkg::MODE_RECORD_END, 8'hFF);
      send_item(tcfh_pkg::MODE_FIELD_END, 8'h00);
      send_item(tcfh_pkg::MODE_RECORD_END, 8'h00);
      // leading spaces dropped, case fold, inner spaces kept, trailing dropped
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::LOWER_A);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::LOWER_Z);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      send_item(tcfh_pkg::MODE_BYTE, 8'h5A);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      send_item(tcfh_pkg::MODE_FIELD_END, 8'h41);
      // bytes just outside the lower-case range must pass unchanged
      send_item(tcfh_pkg::MODE_BYTE, 8'h60);
      send_item(tcfh_pkg::MODE_BYTE, 8'h7B);
      send_item(tcfh_pkg::MODE_BYTE, 8'hFF);
      send_item(tcfh_pkg::MODE_BYTE, 8'h01);
      // held spaces dropped at nul, later bytes ignored
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::NUL_CHAR);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::LOWER_A);
      send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      // unused mode mid-field must change nothing
      send_item(MODE_UNUSED, 8'h55);
      send_item(tcfh_pkg::MODE_RECORD_END, 8'hAA);
   endtask

   // run of spaces longer than the held count can take, then text flushes it
   task automatic test_space_saturation();
      send_item(tcfh_pkg::MODE_BYTE, 8'h78);
      repeat (tcfh_pkg::MAX_FIELD_BYTES + 40)
         send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
      send_item(tcfh_pkg::MODE_BYTE, 8'h79);
      send_item(tcfh_pkg::MODE_RECORD_END, 8'h00);
   endtask

   // receiver holds off for a long time while the sender keeps pushing records
   task automatic test_back_pressure();
      hold_request = 400;
      sender_no_gaps = 1'b1;
      for (int r = 0; r < 40; r++) begin
         send_item(tcfh_pkg::MODE_BYTE, pick_text_byte());
         send_item(tcfh_pkg::MODE_BYTE, pick_text_byte());
         send_item(tcfh_pkg::MODE_RECORD_END, 8'($urandom));
      end
      sender_no_gaps = 1'b0;
   endtask

   // well-formed records with random content, some noise and broken records
   task automatic test_random_records();
      int goal;
      int n_fields;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         // occasional stretches with no idling on either side
         sender_no_gaps = ($urandom_range(0, 5) == 0);
         rsp_no_stall = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) == 0) begin
            // noise: any mode, any byte
            repeat ($urandom_range(1, 8))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            continue;
         end
         n_fields = $urandom_range(1, 4);
         for (int f = 0; f < n_fields; f++) begin
            repeat ($urandom_range(0, 3))
               send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
            repeat ($urandom_range(0, 8)) send_item(tcfh_pkg::MODE_BYTE, pick_text_byte());
            // a longer inner space run now and then, hashed only if text follows
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(2, 20))
                  send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
               repeat ($urandom_range(0, 3))
                  send_item(tcfh_pkg::MODE_BYTE, pick_text_byte());
            end
            repeat ($urandom_range(0, 4))
               send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::SPACE_CHAR);
            if ($urandom_range(0, 7) == 0) begin
               send_item(tcfh_pkg::MODE_BYTE, tcfh_pkg::NUL_CHAR);
               repeat ($urandom_range(0, 3))
                  send_item(tcfh_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 15) == 0)
               send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
            send_item((f == n_fields - 1) ? tcfh_pkg::MODE_RECORD_END :
                      tcfh_pkg::MODE_FIELD_END, 8'($urandom_range(0, 255)));
         end
      end
      sender_no_gaps = 1'b0;
      rsp_no_stall = 1'b0;
      // close whatever the noise left open
      send_item(tcfh_pkg::MODE_RECORD_END, 8'($urandom));
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int waited;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = tcfh_pkg::MODE_BYTE;
      req_bus.data_byte = 8'h00;
      clear_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_space_saturation();
      test_back_pressure();
      test_random_records();

      req_bus.valid <= 1'b0;
      // drain outstanding results, bounded
      waited = 0;
      while (pending_digests.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (pending_digests.size() != 0) begin
         $error("%0d record results never arrived", pending_digests.size());
         error_count++;
      end

      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
